>>> hdl/nsr_pkg.sv
package nsr_pkg;

	localparam int RadicandW = 32;
	localparam int RootW     = 32;

	localparam logic [RootW-1:0] RootMax = {RootW{1'b1}};

endpackage

>>> hdl/newton_square_root_unit.sv
// each Newton iteration divides the scaled radicand by the guess in restoring stages, one quotient bit per
// stage, then a further stage averages guess and quotient into the next guess
// throughput: one item per cycle; the whole pipeline holds while the output item is not taken
// reset: arst_n clears all stage valid bits asynchronously, data registers are not reset
module newton_square_root_unit #(
	parameter int ITERATIONS = 10,
	parameter int FRAC_BITS  = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [nsr_pkg::RadicandW-1:0]      radicand,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [nsr_pkg::RootW-1:0]          root
);

	localparam int SW = nsr_pkg::RadicandW + FRAC_BITS;
	localparam int P  = SW + 1;
	localparam int NS = ITERATIONS * P;

	logic          vld_s [NS];
	logic [SW-1:0] scl_s [NS];
	logic [SW-1:0] gss_s [NS];
	logic [SW-1:0] rem_s [NS];
	logic [SW-1:0] quo_s [NS];
	logic          zro_s [NS];

	logic          adv;
	logic [SW-1:0] in_scl;
	logic [SW-1:0] in_gss;

	assign adv      = !vld_s[NS-1] || out_ready;
	assign in_ready = adv;
	assign in_scl   = SW'(radicand) << FRAC_BITS;
	assign in_gss   = SW'(radicand >> 1);

	genvar k;
	generate
		for (k = 0; k < NS; k++) begin : g_stage
			localparam int J = k % P;
			logic          pv;
			logic [SW-1:0] ps;
			logic [SW-1:0] pg;
			logic [SW-1:0] pr;
			logic [SW-1:0] pq;
			logic          pz;
			logic [SW-1:0] nr;
			logic [SW-1:0] nq;
			logic [SW-1:0] ng;
			logic          nz;

			if (k == 0) begin : g_src_in
				assign pv = in_valid;
				assign ps = in_scl;
				assign pg = in_gss;
				assign pr = '0;
				assign pq = '0;
				assign pz = 1'b0;
			end else begin : g_src_prev
				assign pv = vld_s[k-1];
				assign ps = scl_s[k-1];
				assign pg = gss_s[k-1];
				assign pr = rem_s[k-1];
				assign pq = quo_s[k-1];
				assign pz = zro_s[k-1];
			end

			if (J < SW) begin : g_div
				localparam int B = SW - 1 - J;
				logic [SW:0] t;
				logic        ge;
				// a zero guess ends the item with a zero root
				if (J == 0) begin : g_zchk
					assign nz = pz || (pg == '0);
				end else begin : g_zpass
					assign nz = pz;
				end
				always_comb begin
					t  = {pr, ps[B]};
					ge = t >= {1'b0, pg};
					nr = ge ? SW'(t - {1'b0, pg}) : t[SW-1:0];
					nq = pq;
					nq[B] = ge;
				end
				assign ng = pg;
			end else begin : g_upd
				logic [SW:0] sum;
				assign sum = {1'b0, pg} + {1'b0, pq};
				assign ng  = sum[SW:1];
				assign nr  = '0;
				assign nq  = '0;
				assign nz  = pz;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (adv) begin
					vld_s[k] <= pv;
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					scl_s[k] <= ps;
					gss_s[k] <= ng;
					rem_s[k] <= nr;
					quo_s[k] <= nq;
					zro_s[k] <= nz;
				end
			end
		end
	endgenerate

	assign out_valid = vld_s[NS-1];

	always_comb begin
		if (zro_s[NS-1] || gss_s[NS-1] == '0) begin
			root = '0;
		end else if (gss_s[NS-1] > SW'(nsr_pkg::RootMax)) begin
			root = nsr_pkg::RootMax;
		end else begin
			root = gss_s[NS-1][nsr_pkg::RootW-1:0];
		end
	end

endmodule

>>> hdl/nsr_checker.sv
module nsr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [nsr_pkg::RadicandW-1:0] radicand,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [nsr_pkg::RootW-1:0]     root
);

	// pipeline only stalls when the output item is held
	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow output stall");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(root))
		else $error("output item changed while stalled");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(radicand))
		else $error("input item changed while waiting");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output valid right after reset");

	// a stall on the output freezes the pipeline, so no item is taken in that cycle
	a_no_accept_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("item accepted while output stalled");

endmodule

bind newton_square_root_unit nsr_checker u_nsr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.radicand  (radicand),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.root      (root)
);
